// ===== rtl/lppd_pkg.sv =====
// ----------------------------------------------------------------------------
// lppd_pkg
// Types and codes shared by the length-prefixed packet deframer modules.
// ----------------------------------------------------------------------------
package lppd_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Status codes carried in status
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Reset value of the maximum payload length register
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  // Last CRC byte position (four bytes, little endian)
  localparam logic [1:0] CRC_LAST = 2'd3;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_CMD     = 5'b00001,
    PH_LEN_LO  = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cmd_out;
    logic [15:0] length_out;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [31:0] crc_out;
  } out_item_t;

endpackage

// ===== rtl/lppd_in_stage.sv =====
// ----------------------------------------------------------------------------
// lppd_in_stage
// Input register: holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module lppd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lppd_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              item_valid,
  output lppd_pkg::in_item_t item
);
  import lppd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  // Take a new transaction when empty or when the held one moves on
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== rtl/lppd_parser.sv =====
// ----------------------------------------------------------------------------
// lppd_parser
// Frame parser state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module lppd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                step,
  input  lppd_pkg::in_item_t  item,
  output lppd_pkg::out_item_t result
);
  import lppd_pkg::*;

  logic [15:0] max_payload_r;
  phase_t      phase_r,      phase_nxt;
  logic [7:0]  command_r,    command_nxt;
  logic [15:0] length_r,     length_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [31:0] crc_r,        crc_nxt;
  logic [1:0]  crc_count_r,  crc_count_nxt;
  logic        error_r,      error_nxt;
  logic [15:0] index_inc;
  logic [15:0] length_full;

  assign index_inc   = byte_index_r + 16'd1;
  assign length_full = {item.data_byte, length_r[7:0]};

  // Next state and result for the held request
  always_comb begin
    phase_nxt      = phase_r;
    command_nxt    = command_r;
    length_nxt     = length_r;
    byte_index_nxt = byte_index_r;
    crc_nxt        = crc_r;
    crc_count_nxt  = crc_count_r;
    error_nxt      = error_r;
    result         = '0;
    result.status  = ST_BUSY;

    unique case (item.req_type)
      REQ_RESTART: begin
        phase_nxt      = PH_CMD;
        command_nxt    = '0;
        length_nxt     = '0;
        byte_index_nxt = '0;
        crc_nxt        = '0;
        crc_count_nxt  = '0;
        error_nxt      = 1'b0;
      end
      REQ_TIMEOUT: begin
        error_nxt     = 1'b1;
        result.status = ST_ERR;
      end
      REQ_NONE: begin
        result.status = error_r ? ST_ERR : ST_BUSY;
      end
      default: begin
        if (error_r) begin
          result.status = ST_ERR;
        end else begin
          unique case (phase_r)
            PH_LEN_LO: begin
              length_nxt = {8'd0, item.data_byte};
              phase_nxt  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              length_nxt = length_full;
              if (length_full > max_payload_r) begin
                error_nxt     = 1'b1;
                result.status = ST_ERR;
              end else if (length_full == '0) begin
                crc_count_nxt = '0;
                phase_nxt     = PH_CRC;
              end else begin
                byte_index_nxt = '0;
                phase_nxt      = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              result.payload_valid = 1'b1;
              result.payload_byte  = item.data_byte;
              result.payload_index = byte_index_r;
              byte_index_nxt       = index_inc;
              if (index_inc >= length_r) begin
                crc_count_nxt = '0;
                phase_nxt     = PH_CRC;
              end
            end
            PH_CRC: begin
              // Assemble little endian; first byte restarts the word
              unique case (crc_count_r)
                2'd0:    crc_nxt = {24'd0, item.data_byte};
                2'd1:    crc_nxt = crc_r | {16'd0, item.data_byte, 8'd0};
                2'd2:    crc_nxt = crc_r | {8'd0, item.data_byte, 16'd0};
                default: crc_nxt = crc_r | {item.data_byte, 24'd0};
              endcase
              if (crc_count_r == CRC_LAST) begin
                crc_count_nxt  = '0;
                phase_nxt      = PH_CMD;
                result.status  = ST_DONE;
                result.crc_out = crc_nxt;
              end else begin
                crc_count_nxt = crc_count_r + 2'd1;
              end
            end
            default: begin
              command_nxt = item.data_byte;
              phase_nxt   = PH_LEN_LO;
            end
          endcase
        end
      end
    endcase

    result.cmd_out    = command_nxt;
    result.length_out = length_nxt;
  end

  // Advance parser state once per consumed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      command_r    <= '0;
      length_r     <= '0;
      byte_index_r <= '0;
      crc_r        <= '0;
      crc_count_r  <= '0;
      error_r      <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      command_r    <= command_nxt;
      length_r     <= length_nxt;
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
      crc_count_r  <= crc_count_nxt;
      error_r      <= error_nxt;
    end
  end

  // Maximum payload length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

endmodule

// ===== rtl/lppd_out_stage.sv =====
// ----------------------------------------------------------------------------
// lppd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lppd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  lppd_pkg::out_item_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output lppd_pkg::out_item_t out_data
);
  import lppd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // Load when empty or when the held result is taken this cycle
  assign advance   = item_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= result;
    end
  end

endmodule

// ===== rtl/length_prefixed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Parses command / length / payload / CRC frames, one request per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one request per
//   transaction: a received byte, a timeout event, a restart or none. Each request
//   produces exactly one result transaction on out_valid/out_ready/out_data:
//   status, current command and length, a streamed payload byte with its
//   index, and the assembled CRC word when a frame completes.
//   cfg_we/cfg_wdata write the maximum payload length; write only while idle.
//   An accepted request passes the input register, then the combinational
//   parser update, then the result register. Throughput: one request per
//   cycle while out_ready is high, set by the parser update between them.
//   Reset (rst_n low, synchronous) empties both registers, returns the
//   parser to expect a command byte, clears the error flag and sets the
//   maximum payload length to 1024.
//   When the receiver stalls, the result register holds its transaction and
//   the input register absorbs one more; in_ready then drops until
//   out_ready returns.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lppd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lppd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import lppd_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  out_item_t result;

  lppd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lppd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .result    (result)
  );

  lppd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
